// ----- sv/voxel_grid_box_occupancy_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the voxel grid box occupancy core
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef VOXEL_GRID_BOX_OCCUPANCY_CORE_MACROS_SVH
`define VOXEL_GRID_BOX_OCCUPANCY_CORE_MACROS_SVH

// same-cycle implication
`define VGBO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vgbo assertion failed");

// next-cycle implication
`define VGBO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vgbo assertion failed");

`endif

// ----- sv/vgbo_pkg.sv -----
// ---------------------------------------------------------------------------
// vgbo_pkg
// Shared types, field widths and codes of the voxel grid box occupancy core.
// ---------------------------------------------------------------------------
`default_nettype none

package vgbo_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int CELL_COUNT_DEF = 4096;
	localparam int ID_BITS_DEF    = 16;

	localparam int DIM_W     = 5;   // grid dimension registers
	localparam int POS_W     = 4;
	localparam int SIZE_W    = 5;
	localparam int ID_W      = 16;  // item id on the ports
	localparam int WD_W      = 2 * DIM_W;
	localparam int N_W       = 3 * DIM_W;
	localparam int IDX_W     = 20;  // signed walk index, covers wrap below zero
	localparam int CFG_IDX_W = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		ACT_READ      = 3'd0,
		ACT_WRITE     = 3'd1,
		ACT_FILL_BOX  = 3'd2,
		ACT_CLEAR_BOX = 3'd3,
		ACT_OVERLAP   = 3'd4,
		ACT_FIND      = 3'd5,
		ACT_CLEAR_ALL = 3'd6
	} act_t;

	typedef struct packed {
		act_t              action;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [SIZE_W-1:0] size_z;
		logic [ID_W-1:0]   item_id;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0] read_id;
		logic            success;
		logic            hit;
	} out_t;

	// effective grid shape, handed from the config block to the sequencer
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] d;
		logic [DIM_W-1:0] h;
		logic [WD_W-1:0]  wd;
		logic [N_W-1:0]   n;   // cells in use, capped at the store size
	} geom_t;

	// register value saturated to 1..max_dim
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r, input int max_dim);
		logic [DIM_W-1:0] v;
		if (r == '0) begin
			v = DIM_W'(1);
		end else if (int'(r) > max_dim) begin
			v = DIM_W'(max_dim);
		end else begin
			v = r;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- sv/voxel_grid_box_occupancy_core.sv -----
// ---------------------------------------------------------------------------
// voxel_grid_box_occupancy_core
// Row-major 3D occupancy grid of item ids with box fill, overlap and search.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one action per
//    transaction; output channel out_valid/out_ready/out_data returns exactly
//    one result transaction per action, in order.
//  - Config port: cfg_wr_en/cfg_index/cfg_wdata writes width, depth, height.
//    Write only while the core is idle. A write that changes an effective
//    dimension starts a clearing sweep of all CELL_COUNT cells.
//  - Actions run one at a time. Box fill and clear walk the box cells, an
//    overlap query walks until a hit or the last box cell, find walks up to
//    cells_in_use cells, clear all sweeps every cell. Walk speed is set by the
//    single memory port: the walker touches one cell per cycle.
//  - After reset the core sweeps all CELL_COUNT cells to zero (in_ready low
//    meanwhile); config writes are taken during the sweep.
//  - Results sit in an output register; a stalled receiver holds the current
//    result while the next action is accepted and executed. It then waits
//    until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

`include "voxel_grid_box_occupancy_core_macros.svh"

module voxel_grid_box_occupancy_core #(
	parameter int MAX_DIM    = vgbo_pkg::MAX_DIM_DEF,
	parameter int CELL_COUNT = vgbo_pkg::CELL_COUNT_DEF,
	parameter int ID_BITS    = vgbo_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [vgbo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vgbo_pkg::DIM_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vgbo_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vgbo_pkg::out_t                  out_data
);

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int DIM_W  = vgbo_pkg::DIM_W;
	localparam int WD_W   = vgbo_pkg::WD_W;
	localparam int N_W    = vgbo_pkg::N_W;

	// config registers, raw values as written
	logic [DIM_W-1:0] grid_width_q, grid_depth_q, grid_height_q;
	logic [DIM_W-1:0] w_new, d_new, h_new;
	logic [DIM_W-1:0] w_eff, d_eff, h_eff;
	logic clear_req;

	// derived shape, registered so no multiply chains into the sequencer
	logic [WD_W-1:0] wd_q;
	logic [N_W-1:0]  n_q, whd_c, n_c;
	vgbo_pkg::geom_t geom;

	logic resp_valid, resp_take;
	vgbo_pkg::out_t resp_data;
	logic out_valid_q;
	vgbo_pkg::out_t out_data_q;

	logic               mem_we, mem_re, mem_neg, mem_match;
	logic [ADDR_W-1:0]  mem_addr;
	logic [ID_BITS-1:0] mem_wdata, mem_key, mem_rdata;

	always_comb begin
		w_new = grid_width_q;
		d_new = grid_depth_q;
		h_new = grid_height_q;
		if (cfg_wr_en) begin
			case (cfg_index)
				vgbo_pkg::CFG_GRID_WIDTH:  w_new = cfg_wdata;
				vgbo_pkg::CFG_GRID_DEPTH:  d_new = cfg_wdata;
				vgbo_pkg::CFG_GRID_HEIGHT: h_new = cfg_wdata;
				default: ;  // no register here, write dropped
			endcase
		end
	end

	assign w_eff = vgbo_pkg::eff_dim(grid_width_q, MAX_DIM);
	assign d_eff = vgbo_pkg::eff_dim(grid_depth_q, MAX_DIM);
	assign h_eff = vgbo_pkg::eff_dim(grid_height_q, MAX_DIM);

	// of config writes, only a change of the saturated shape wipes the store
	assign clear_req = (vgbo_pkg::eff_dim(w_new, MAX_DIM) != w_eff)
		|| (vgbo_pkg::eff_dim(d_new, MAX_DIM) != d_eff)
		|| (vgbo_pkg::eff_dim(h_new, MAX_DIM) != h_eff);

	assign whd_c = N_W'(wd_q) * N_W'(h_eff);
	assign n_c   = (int'(whd_c) > CELL_COUNT) ? N_W'(CELL_COUNT) : whd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= vgbo_pkg::DIM_RESET;
			grid_depth_q  <= vgbo_pkg::DIM_RESET;
			grid_height_q <= vgbo_pkg::DIM_RESET;
			wd_q          <= '0;
			n_q           <= '0;
		end else begin
			grid_width_q  <= w_new;
			grid_depth_q  <= d_new;
			grid_height_q <= h_new;
			wd_q          <= WD_W'(w_eff) * WD_W'(d_eff);
			n_q           <= n_c;
		end
	end

	assign geom.w  = w_eff;
	assign geom.d  = d_eff;
	assign geom.h  = h_eff;
	assign geom.wd = wd_q;
	assign geom.n  = n_q;

	vgbo_seq #(
		.CELL_COUNT(CELL_COUNT),
		.ID_BITS   (ID_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.clear_req (clear_req),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.resp_valid(resp_valid),
		.resp_take (resp_take),
		.resp_data (resp_data),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_key   (mem_key),
		.mem_neg   (mem_neg),
		.mem_rdata (mem_rdata),
		.mem_match (mem_match)
	);

	// reads and writes are never issued together, and a write lands before
	// the next read can be issued, so no forwarding path is needed
	vgbo_cell_store #(
		.DEPTH (CELL_COUNT),
		.DATA_W(ID_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.key  (mem_key),
		.neg  (mem_neg),
		.rdata(mem_rdata),
		.match(mem_match)
	);

	// output register: frees the sequencer while the receiver stalls
	assign resp_take = resp_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_take) begin
			out_data_q <= resp_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// one action in flight: no accept right after an accept
	`VGBO_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// a shape change blocks new actions while the store is swept
	`VGBO_ASSERT_NEXT(a_clear_blocks, clear_req, !in_ready)
	// the single memory port never sees a read and a write together
	`VGBO_ASSERT_NOW(a_port_excl, mem_we, !mem_re)
	// a result shows up only after the sequencer offered one
	`VGBO_ASSERT_NOW(a_out_from_resp, $rose(out_valid), $past(resp_valid))

endmodule

`default_nettype wire

// ----- sv/vgbo_cell_store.sv -----
// ---------------------------------------------------------------------------
// vgbo_cell_store
// Cell memory with registered read data and the probe compare on its output.
// ---------------------------------------------------------------------------
`default_nettype none

module vgbo_cell_store #(
	parameter int DEPTH  = vgbo_pkg::CELL_COUNT_DEF,
	parameter int DATA_W = vgbo_pkg::ID_BITS_DEF,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [DATA_W-1:0] key,
	input  logic              neg,
	output logic [DATA_W-1:0] rdata,
	output logic              match
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	// find: equal to key; overlap: key is zero and the sense is inverted
	assign match = (rdata_q == key) != neg;

endmodule

`default_nettype wire

// ----- sv/vgbo_seq.sv -----
// ---------------------------------------------------------------------------
// vgbo_seq
// Action sequencer: box and store walks, clearing sweeps, result building.
// ---------------------------------------------------------------------------
`default_nettype none

module vgbo_seq #(
	parameter int CELL_COUNT = vgbo_pkg::CELL_COUNT_DEF,
	parameter int ID_BITS    = vgbo_pkg::ID_BITS_DEF,
	localparam int ADDR_W    = $clog2(CELL_COUNT)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vgbo_pkg::geom_t      geom,
	input  logic                 clear_req,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vgbo_pkg::in_t        in_data,
	output logic                 resp_valid,
	input  logic                 resp_take,
	output vgbo_pkg::out_t       resp_data,
	output logic                 mem_we,
	output logic                 mem_re,
	output logic [ADDR_W-1:0]    mem_addr,
	output logic [ID_BITS-1:0]   mem_wdata,
	output logic [ID_BITS-1:0]   mem_key,
	output logic                 mem_neg,
	input  logic [ID_BITS-1:0]   mem_rdata,
	input  logic                 mem_match
);

	localparam int IDX_W  = vgbo_pkg::IDX_W;
	localparam int SIZE_W = vgbo_pkg::SIZE_W;
	localparam logic signed [IDX_W-1:0] CELLS_S   = IDX_W'(CELL_COUNT);
	localparam logic signed [IDX_W-1:0] LAST_CELL = IDX_W'(CELL_COUNT - 1);

	typedef enum logic [6:0] {
		S_SWEEP    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_SETUP    = 7'b0000100,
		S_DISPATCH = 7'b0001000,
		S_WALK     = 7'b0010000,
		S_DRAIN    = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic signed [IDX_W-1:0] idx_q, idx_d;
	logic sweep_res_q, sweep_res_d;
	logic chk_s1, chk_d;

	vgbo_pkg::in_t item_s1;
	logic signed [IDX_W-1:0] org_s1, rinc_s1, pinc_s1;
	logic fit_s1, inr_s1, zero_s1, neg_s1;
	logic [ID_BITS-1:0] wdata_s1, key_s1;
	logic probe_q, probe_d, find_q, find_d;
	logic [SIZE_W-1:0] cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
	vgbo_pkg::out_t res_q, res_d;

	logic accept, match, probe_ok, walk_last;
	logic signed [IDX_W-1:0] org_c, rinc_c, n_s, n_last;
	logic [SIZE_W-1:0] sx_last, sy_last, sz_last;
	logic fit_c, inr_c, zero_c;

	assign in_ready = (state_q == S_IDLE) && !clear_req;
	assign accept   = in_valid && in_ready;

	// origin and per-row wrap step; multiplies are narrow and run in parallel
	assign org_c = IDX_W'(item_s1.pos_x)
		+ IDX_W'(geom.w) * IDX_W'(item_s1.pos_y)
		+ IDX_W'(geom.wd) * IDX_W'(item_s1.pos_z);
	assign rinc_c = IDX_W'(1) + IDX_W'(geom.w) - IDX_W'(item_s1.size_x);

	assign zero_c = (item_s1.size_x == '0) || (item_s1.size_y == '0) || (item_s1.size_z == '0);
	assign fit_c = !zero_c
		&& (6'(item_s1.pos_x) + 6'(item_s1.size_x) <= 6'(geom.w))
		&& (6'(item_s1.pos_y) + 6'(item_s1.size_y) <= 6'(geom.d))
		&& (6'(item_s1.pos_z) + 6'(item_s1.size_z) <= 6'(geom.h));
	assign inr_c = (5'(item_s1.pos_x) < geom.w) && (5'(item_s1.pos_y) < geom.d)
		&& (5'(item_s1.pos_z) < geom.h) && (org_c < CELLS_S);

	assign n_s    = signed'(IDX_W'(geom.n));
	assign n_last = n_s - IDX_W'(1);

	assign sx_last = item_s1.size_x - SIZE_W'(1);
	assign sy_last = item_s1.size_y - SIZE_W'(1);
	assign sz_last = item_s1.size_z - SIZE_W'(1);

	assign probe_ok  = !idx_q[IDX_W-1] && (idx_q < n_s);
	assign walk_last = find_q ? (idx_q == n_last)
		: (zero_s1 || ((cx_q == sx_last) && (cy_q == sy_last) && (cz_q == sz_last)));
	assign match = chk_s1 && mem_match;

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		sweep_res_d = sweep_res_q;
		chk_d       = 1'b0;
		probe_d     = probe_q;
		find_d      = find_q;
		cx_d        = cx_q;
		cy_d        = cy_q;
		cz_d        = cz_q;
		res_d       = res_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
				if (idx_q == LAST_CELL) begin
					idx_d = '0;
					if (sweep_res_q) begin
						res_d.success = 1'b1;
						state_d = S_RESP;
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_IDLE: begin
				if (accept) begin
					res_d   = '0;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				cx_d    = '0;
				cy_d    = '0;
				cz_d    = '0;
				probe_d = 1'b0;
				find_d  = 1'b0;
				idx_d   = org_s1;
				state_d = S_RESP;
				case (item_s1.action)
					vgbo_pkg::ACT_READ: begin
						if (inr_s1) begin
							mem_re  = 1'b1;
							state_d = S_DRAIN;
						end
					end
					vgbo_pkg::ACT_WRITE: begin
						if (inr_s1) begin
							mem_we = 1'b1;
							res_d.success = 1'b1;
						end
					end
					vgbo_pkg::ACT_FILL_BOX, vgbo_pkg::ACT_CLEAR_BOX: begin
						if (fit_s1) begin
							state_d = S_WALK;
						end
					end
					vgbo_pkg::ACT_OVERLAP: begin
						probe_d = 1'b1;
						if (org_s1 < n_s) begin
							state_d = S_WALK;
						end
					end
					vgbo_pkg::ACT_FIND: begin
						probe_d = 1'b1;
						find_d  = 1'b1;
						idx_d   = '0;
						state_d = S_WALK;
					end
					vgbo_pkg::ACT_CLEAR_ALL: begin
						idx_d       = '0;
						sweep_res_d = 1'b1;
						state_d     = S_SWEEP;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_WALK: begin
				if (probe_q && match) begin
					// early out; a read already in flight is simply dropped
					res_d.hit = 1'b1;
					state_d   = S_RESP;
				end else begin
					if (probe_q) begin
						mem_re = probe_ok;
						chk_d  = probe_ok;
					end else begin
						mem_we = idx_q < CELLS_S;
					end
					if (walk_last) begin
						if (probe_q) begin
							state_d = S_DRAIN;
						end else begin
							res_d.success = 1'b1;
							state_d = S_RESP;
						end
					end else if (find_q) begin
						idx_d = idx_q + IDX_W'(1);
					end else if (cx_q != sx_last) begin
						cx_d  = cx_q + SIZE_W'(1);
						idx_d = idx_q + IDX_W'(1);
					end else begin
						cx_d = '0;
						if (cy_q != sy_last) begin
							cy_d  = cy_q + SIZE_W'(1);
							idx_d = idx_q + rinc_s1;
						end else begin
							cy_d  = '0;
							cz_d  = cz_q + SIZE_W'(1);
							idx_d = idx_q + pinc_s1;
						end
					end
				end
			end
			S_DRAIN: begin
				if (item_s1.action == vgbo_pkg::ACT_READ) begin
					res_d.read_id = 16'(mem_rdata);
					res_d.success = 1'b1;
				end else if (match) begin
					res_d.hit = 1'b1;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (resp_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// dimension change: restart the clearing sweep, no result
		if (clear_req) begin
			state_d     = S_SWEEP;
			idx_d       = '0;
			sweep_res_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			idx_q       <= '0;
			sweep_res_q <= 1'b0;
			chk_s1      <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			sweep_res_q <= sweep_res_d;
			chk_s1      <= chk_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (state_q == S_SETUP) begin
			org_s1   <= org_c;
			rinc_s1  <= rinc_c;
			fit_s1   <= fit_c;
			inr_s1   <= inr_c;
			zero_s1  <= zero_c;
			neg_s1   <= item_s1.action == vgbo_pkg::ACT_OVERLAP;
			key_s1   <= (item_s1.action == vgbo_pkg::ACT_FIND) ? ID_BITS'(item_s1.item_id) : '0;
			wdata_s1 <= (item_s1.action == vgbo_pkg::ACT_CLEAR_BOX) ? '0
				: ID_BITS'(item_s1.item_id);
		end
		if (state_q == S_DISPATCH) begin
			// plane wrap step: row step plus the skipped rows of one plane
			pinc_s1 <= rinc_s1 + IDX_W'(geom.w)
				* (IDX_W'(geom.d) - IDX_W'(item_s1.size_y));
		end
		probe_q <= probe_d;
		find_q  <= find_d;
		cx_q    <= cx_d;
		cy_q    <= cy_d;
		cz_q    <= cz_d;
		res_q   <= res_d;
	end

	assign mem_addr  = (state_q == S_DISPATCH) ? org_s1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
	assign mem_wdata = (state_q == S_SWEEP) ? '0 : wdata_s1;
	assign mem_key   = key_s1;
	assign mem_neg   = neg_s1;

	assign resp_valid = state_q == S_RESP;
	assign resp_data  = res_q;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_grid_box_occupancy_core. A scripted opening
// covers corner cases, then randomized transactions run over several grid
// shapes. Each result is compared, in order, against a typed-in answer or
// against a cycle-free software mirror of the grid store.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int CFG_IDX_W = vgbo_pkg::CFG_IDX_W;
	localparam int DIM_W     = vgbo_pkg::DIM_W;
	localparam int ID_W      = vgbo_pkg::ID_W;
	localparam int POS_W     = vgbo_pkg::POS_W;
	localparam int SIZE_W    = vgbo_pkg::SIZE_W;

	typedef vgbo_pkg::act_t act_t;
	typedef vgbo_pkg::in_t  in_t;
	typedef vgbo_pkg::out_t out_t;

	localparam act_t ACT_READ      = vgbo_pkg::ACT_READ;
	localparam act_t ACT_WRITE     = vgbo_pkg::ACT_WRITE;
	localparam act_t ACT_FILL_BOX  = vgbo_pkg::ACT_FILL_BOX;
	localparam act_t ACT_CLEAR_BOX = vgbo_pkg::ACT_CLEAR_BOX;
	localparam act_t ACT_OVERLAP   = vgbo_pkg::ACT_OVERLAP;
	localparam act_t ACT_FIND      = vgbo_pkg::ACT_FIND;
	localparam act_t ACT_CLEAR_ALL = vgbo_pkg::ACT_CLEAR_ALL;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = vgbo_pkg::CFG_GRID_WIDTH;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = vgbo_pkg::CFG_GRID_DEPTH;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = vgbo_pkg::CFG_GRID_HEIGHT;
	localparam logic [DIM_W-1:0]     DIM_RESET       = vgbo_pkg::DIM_RESET;

	localparam int STORE_CELLS   = vgbo_pkg::CELL_COUNT_DEF;
	localparam int MAX_EXTENT    = vgbo_pkg::MAX_DIM_DEF;
	localparam int PHASE_ITEMS   = 53;
	localparam int HOLD_CYCLES   = 300;    // long receiver back-pressure
	localparam int SETTLE_CYCLES = 8;      // idle gap before a register write
	localparam int DRAIN_CYCLES  = 40;     // quiet time after the last result
	localparam int QUIET_LIMIT   = 40000;  // cycles with no transaction at all
	localparam int SHOW_LIMIT    = 10;

	// action code that the block must ignore
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;

	voxel_grid_box_occupancy_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Mirror of the grid store and its shape registers
	// -----------------------------------------------------------------------
	logic [ID_W-1:0]  grid_image [STORE_CELLS];
	logic [DIM_W-1:0] reg_width, reg_depth, reg_height;

	out_t            pending_results [$];  // answers still owed by the block
	logic [ID_W-1:0] recent_ids [$];       // ids lately written, for find hits

	int  fail_count = 0;
	int  shown      = 0;
	int  ready_pct  = 60;
	bit  hold_req   = 1'b0;
	int  quiet_cycles = 0;
	out_t want_now;

	// register value saturated to 1..MAX_EXTENT
	function automatic int grid_extent(input logic [DIM_W-1:0] r);
		if (r == '0)
			return 1;
		if (int'(r) > MAX_EXTENT)
			return MAX_EXTENT;
		return int'(r);
	endfunction

	function automatic int cells_in_use();
		int n;
		n = grid_extent(reg_width) * grid_extent(reg_depth) * grid_extent(reg_height);
		return (n > STORE_CELLS) ? STORE_CELLS : n;
	endfunction

	function automatic void wipe_grid();
		foreach (grid_image[i])
			grid_image[i] = '0;
	endfunction

	// a shape change of any axis empties the store
	function automatic void track_reg(input logic [CFG_IDX_W-1:0] idx,
	                                  input logic [DIM_W-1:0] val);
		int ow, od, oh;
		ow = grid_extent(reg_width);
		od = grid_extent(reg_depth);
		oh = grid_extent(reg_height);
		case (idx)
			CFG_GRID_WIDTH:  reg_width  = val;
			CFG_GRID_DEPTH:  reg_depth  = val;
			CFG_GRID_HEIGHT: reg_height = val;
			default: return;
		endcase
		if (ow != grid_extent(reg_width) || od != grid_extent(reg_depth) ||
		    oh != grid_extent(reg_height))
			wipe_grid();
	endfunction

	// fill or clear a box; refused when an extent is zero or the box overhangs
	function automatic bit box_store(input int px, py, pz, sx, sy, sz,
	                                 input logic [ID_W-1:0] v);
		int w, d, h;
		w = grid_extent(reg_width);
		d = grid_extent(reg_depth);
		h = grid_extent(reg_height);
		if (sx == 0 || sy == 0 || sz == 0)
			return 1'b0;
		if (px + sx > w || py + sy > d || pz + sz > h)
			return 1'b0;
		for (int z = pz; z < pz + sz; z++)
			for (int y = py; y < py + sy; y++)
				for (int x = px; x < px + sx; x++)
					grid_image[x + w * y + w * d * z] = v;
		return 1'b1;
	endfunction

	// overlap walk over linear indices: rows may wrap, off-store indices skipped
	function automatic bit box_occupied(input int px, py, pz, sx, sy, sz);
		int w, d, n, idx, total, plane, inc;
		w     = grid_extent(reg_width);
		d     = grid_extent(reg_depth);
		n     = cells_in_use();
		idx   = px + w * py + w * d * pz;
		total = sx * sy * sz;
		plane = sx * sy;
		if (idx < 0 || idx >= n)
			return 1'b0;
		if (grid_image[idx] != '0)
			return 1'b1;
		for (int i = 1; i < total; i++) begin
			inc = 1;
			if (i % sx == 0)
				inc += w - sx;
			if (i % plane == 0)
				inc += w * (d - sy);
			idx += inc;
			if (idx >= 0 && idx < n && grid_image[idx] != '0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// expected answer of one transaction; updates the mirror
	function automatic out_t predict_action(input in_t t);
		out_t r;
		int   w, d, h, n, idx, px, py, pz, sx, sy, sz;
		bit   in_grid;
		r  = '0;
		w  = grid_extent(reg_width);
		d  = grid_extent(reg_depth);
		h  = grid_extent(reg_height);
		px = int'(t.pos_x);
		py = int'(t.pos_y);
		pz = int'(t.pos_z);
		sx = int'(t.size_x);
		sy = int'(t.size_y);
		sz = int'(t.size_z);
		idx     = px + w * py + w * d * pz;
		in_grid = px < w && py < d && pz < h && idx < STORE_CELLS;
		case (t.action)
			ACT_READ: begin
				if (in_grid) begin
					r.read_id = grid_image[idx];
					r.success = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (in_grid) begin
					grid_image[idx] = t.item_id;
					r.success = 1'b1;
				end
			end
			ACT_FILL_BOX:  r.success = box_store(px, py, pz, sx, sy, sz, t.item_id);
			ACT_CLEAR_BOX: r.success = box_store(px, py, pz, sx, sy, sz, '0);
			ACT_OVERLAP:   r.hit = box_occupied(px, py, pz, sx, sy, sz);
			ACT_FIND: begin
				n = cells_in_use();
				for (int i = 0; i < n; i++) begin
					if (grid_image[i] == t.item_id) begin
						r.hit = 1'b1;
						break;
					end
				end
			end
			ACT_CLEAR_ALL: begin
				wipe_grid();
				r.success = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Scripted opening: corner cases, answers typed in where obvious
	// -----------------------------------------------------------------------
	typedef struct {
		bit               regrid;  // reshape only, no transaction
		logic [DIM_W-1:0] new_w, new_d, new_h;
		in_t              cmd;
		bit               fixed;   // answer below is typed in
		out_t             want;
	} script_row_t;

	script_row_t script [$];

	function automatic void add_cmd(input bit fixed, input logic [2:0] act,
	                                input int px, py, pz, sx, sy, sz, id,
	                                input int rid, input bit ok, input bit hit);
		script_row_t r;
		r.regrid       = 1'b0;
		r.new_w        = '0;
		r.new_d        = '0;
		r.new_h        = '0;
		r.cmd.action   = act_t'(act);
		r.cmd.pos_x    = POS_W'(px);
		r.cmd.pos_y    = POS_W'(py);
		r.cmd.pos_z    = POS_W'(pz);
		r.cmd.size_x   = SIZE_W'(sx);
		r.cmd.size_y   = SIZE_W'(sy);
		r.cmd.size_z   = SIZE_W'(sz);
		r.cmd.item_id  = ID_W'(id);
		r.fixed        = fixed;
		r.want.read_id = ID_W'(rid);
		r.want.success = ok;
		r.want.hit     = hit;
		script.insert(script.size(), r);
	endfunction

	function automatic void add_regrid(input int w, d, h);
		script_row_t r;
		r.regrid = 1'b1;
		r.new_w  = DIM_W'(w);
		r.new_d  = DIM_W'(d);
		r.new_h  = DIM_W'(h);
		r.cmd    = '0;
		r.fixed  = 1'b0;
		r.want   = '0;
		script.insert(script.size(), r);
	endfunction

	function automatic void build_script();
		// fresh 16x16x16 grid after reset
		add_cmd(1, ACT_READ,      0,  0,  0,  1,  1,  1, 0,       0,       1, 0);
		add_cmd(1, ACT_READ,     15, 15, 15,  1,  1,  1, 0,       0,       1, 0);
		add_cmd(1, ACT_FIND,      0,  0,  0,  1,  1,  1, 0,       0,       0, 1); // empty cells found
		add_cmd(1, ACT_FIND,      0,  0,  0,  1,  1,  1, 'hFFFF,  0,       0, 0);
		add_cmd(1, ACT_WRITE,    15, 15, 15,  1,  1,  1, 'hFFFF,  0,       1, 0);
		add_cmd(1, ACT_READ,     15, 15, 15,  1,  1,  1, 0,       'hFFFF,  1, 0);
		add_cmd(1, ACT_FIND,      0,  0,  0,  1,  1,  1, 'hFFFF,  0,       0, 1);
		add_cmd(1, ACT_OVERLAP,   0,  0,  0,  0,  0,  0, 0,       0,       0, 0); // origin only
		add_cmd(1, ACT_WRITE,     0,  0,  0,  1,  1,  1, 1,       0,       1, 0);
		add_cmd(1, ACT_OVERLAP,   0,  0,  0,  0,  5,  0, 0,       0,       0, 1);
		add_cmd(1, ACT_FILL_BOX,  0,  0,  0, 16, 16, 16, 'hA5A5,  0,       1, 0); // whole grid
		add_cmd(1, ACT_FIND,      0,  0,  0,  1,  1,  1, 0,       0,       0, 0);
		add_cmd(0, ACT_CLEAR_BOX, 1,  2,  3,  2,  3,  4, 0,       0,       0, 0);
		add_cmd(1, ACT_FILL_BOX, 15,  0,  0,  2,  1,  1, 7,       0,       0, 0); // overhang
		add_cmd(1, ACT_FILL_BOX,  0,  0,  0,  0,  1,  1, 5,       0,       0, 0); // zero extent
		add_cmd(1, ACT_CLEAR_BOX, 0,  0,  0,  1,  1,  0, 0,       0,       0, 0);
		add_cmd(0, ACT_CLEAR_BOX, 8,  8,  8,  8,  8,  8, 0,       0,       0, 0); // exact fit
		add_cmd(0, ACT_OVERLAP,  14,  0,  0,  4,  1,  1, 0,       0,       0, 0); // row wrap
		add_cmd(1, ACT_CLEAR_ALL, 0,  0,  0,  1,  1,  1, 0,       0,       1, 0);
		add_cmd(1, ACT_OVERLAP,   0,  0,  0, 16, 16, 16, 0,       0,       0, 0);
		// small 3x2x2 grid: out-of-range accesses
		add_regrid(3, 2, 2);
		add_cmd(1, ACT_READ,      3,  0,  0,  1,  1,  1, 0,       0,       0, 0);
		add_cmd(1, ACT_WRITE,     0,  2,  0,  1,  1,  1, 7,       0,       0, 0);
		add_cmd(1, ACT_WRITE,     2,  1,  1,  1,  1,  1, 9,       0,       1, 0);
		add_cmd(1, ACT_OVERLAP,   0,  0,  2,  1,  1,  1, 0,       0,       0, 0); // origin off store
		add_cmd(0, ACT_OVERLAP,   0,  0,  0, 16,  1,  1, 0,       0,       0, 0); // row runs on past the last cell
		add_cmd(1, ACT_UNUSED,   15, 15, 15, 31, 31, 31, 'hFFFF,  0,       0, 0);
		add_cmd(1, ACT_FIND,      0,  0,  0,  1,  1,  1, 9,       0,       0, 1);
	endfunction

	// -----------------------------------------------------------------------
	// Random transaction generator
	// -----------------------------------------------------------------------
	// box extent: mostly small, within the room left on the axis when there is any
	function automatic int fit_extent(input int room, input bit wide);
		if (room < 1)
			return $urandom_range(1, 4);
		if (wide)
			return $urandom_range(1, room);
		return $urandom_range(1, (room < 4) ? room : 4);
	endfunction

	function automatic in_t rand_cmd();
		in_t t;
		int  w, d, h, sel, px, py, pz, sx, sy, sz, axis, big;
		w = grid_extent(reg_width);
		d = grid_extent(reg_depth);
		h = grid_extent(reg_height);
		t = '0;
		sel = $urandom_range(99);
		if (sel < 18)      t.action = ACT_READ;
		else if (sel < 36) t.action = ACT_WRITE;
		else if (sel < 50) t.action = ACT_FILL_BOX;
		else if (sel < 60) t.action = ACT_CLEAR_BOX;
		else if (sel < 81) t.action = ACT_OVERLAP;
		else if (sel < 95) t.action = ACT_FIND;
		else if (sel < 98) t.action = ACT_CLEAR_ALL;
		else               t.action = act_t'(ACT_UNUSED);

		// origin mostly inside the grid, sometimes anywhere
		if ($urandom_range(4) != 0) begin
			px = $urandom_range(w - 1);
			py = $urandom_range(d - 1);
			pz = $urandom_range(h - 1);
		end else begin
			px = $urandom_range(15);
			py = $urandom_range(15);
			pz = $urandom_range(15);
		end

		sel = $urandom_range(99);
		if (t.action == ACT_OVERLAP) begin
			sx = $urandom_range(1, 4);
			sy = $urandom_range(1, 4);
			sz = $urandom_range(1, 4);
			big = $urandom_range(17, 31);
			axis = $urandom_range(2);
			if (sel < 15) begin
				sx = $urandom_range(1, 16);
				sy = $urandom_range(1, 16);
				sz = $urandom_range(1, 16);
			end else if (sel < 22) begin
				// one axis past any grid size, walk wraps
				if (axis == 0) sx = big;
				else if (axis == 1) sy = big;
				else sz = big;
			end else if (sel < 32) begin
				if (axis == 0) sx = 0;
				else if (axis == 1) sy = 0;
				else sz = 0;
			end
		end else begin
			sx = fit_extent(w - px, sel >= 75);
			sy = fit_extent(d - py, sel >= 75);
			sz = fit_extent(h - pz, sel >= 75);
			axis = $urandom_range(2);
			if (sel >= 85 && sel < 95) begin
				sx = $urandom_range(31);
				sy = $urandom_range(31);
				sz = $urandom_range(31);
			end else if (sel >= 95) begin
				if (axis == 0) sx = 0;
				else if (axis == 1) sy = 0;
				else sz = 0;
			end
		end
		t.pos_x  = POS_W'(px);
		t.pos_y  = POS_W'(py);
		t.pos_z  = POS_W'(pz);
		t.size_x = SIZE_W'(sx);
		t.size_y = SIZE_W'(sy);
		t.size_z = SIZE_W'(sz);

		sel = $urandom_range(9);
		if (t.action == ACT_FIND && recent_ids.size() > 0 && sel < 5)
			t.item_id = recent_ids[$urandom_range(recent_ids.size() - 1)];
		else if (sel < 2)
			t.item_id = '0;
		else if (sel == 2)
			t.item_id = '1;
		else if (sel == 3)
			t.item_id = ID_W'($urandom_range(1, 3));
		else
			t.item_id = ID_W'($urandom);

		if (t.action == ACT_WRITE || t.action == ACT_FILL_BOX) begin
			recent_ids.insert(recent_ids.size(), t.item_id);
			if (recent_ids.size() > 8)
				void'(recent_ids.pop_front());
		end
		return t;
	endfunction

	// -----------------------------------------------------------------------
	// Drivers: inputs change on the falling edge
	// -----------------------------------------------------------------------
	// offer one transaction; valid stays up on return so a following call
	// keeps the channel busy without a bubble
	task automatic send_cmd(input in_t t, input bit fixed, input out_t want);
		out_t guess;
		@(negedge clk);
		in_valid = 1'b1;
		in_data  = t;
		do
			@(posedge clk);
		while (!in_ready);
		guess = predict_action(t);
		pending_results.insert(pending_results.size(), fixed ? want : guess);
	endtask

	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	// drop valid and wait for every owed result, then let the block settle
	task automatic settle();
		idle_input(1);
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		track_reg(idx, val);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] w, d, h, input bit spare);
		settle();
		reg_write(CFG_GRID_WIDTH, w);
		reg_write(CFG_GRID_DEPTH, d);
		reg_write(CFG_GRID_HEIGHT, h);
		if (spare)
			reg_write(CFG_SPARE, '1);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// one grid shape, a run of random transactions in bursts
	task automatic run_phase(input logic [DIM_W-1:0] w, d, h, input int pct,
	                         input bit gaps, input bit hold, input bit spare);
		int burst;
		set_grid(w, d, h, spare);
		ready_pct = pct;
		burst = 0;
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (gaps && burst == 0) begin
				idle_input(($urandom_range(9) == 0) ? $urandom_range(10, 40)
				                                    : $urandom_range(1, 6));
				burst = $urandom_range(1, 12);
			end
			send_cmd(rand_cmd(), 1'b0, '0);
			if (burst > 0)
				burst--;
			// receiver freezes while the sender keeps offering
			if (hold && k == 15)
				hold_req = 1'b1;
			// sender waits until the pipe has drained
			if (k == 35) begin
				idle_input(1);
				wait (pending_results.size() == 0);
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// -----------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) < ready_pct);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result checker, sampled on the rising edge
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected result: read_id=%h success=%b hit=%b",
					         out_data.read_id, out_data.success, out_data.hit);
				end
			end else begin
				want_now = pending_results.pop_front();
				if (out_data.read_id !== want_now.read_id ||
				    out_data.success !== want_now.success ||
				    out_data.hit !== want_now.hit) begin
					fail_count++;
					if (shown < SHOW_LIMIT) begin
						shown++;
						$display("mismatch: want id=%h ok=%b hit=%b, got id=%h ok=%b hit=%b",
						         want_now.read_id, want_now.success, want_now.hit,
						         out_data.read_id, out_data.success, out_data.hit);
					end
				end
			end
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		reg_width  = DIM_RESET;
		reg_depth  = DIM_RESET;
		reg_height = DIM_RESET;
		wipe_grid();
		build_script();

		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;

		// scripted part, sender back to back; block sweeps its store first
		foreach (script[i]) begin
			if (script[i].regrid)
				set_grid(script[i].new_w, script[i].new_d, script[i].new_h, 1'b0);
			else
				send_cmd(script[i].cmd, script[i].fixed, script[i].want);
		end

		// random part over several shapes, extremes included
		run_phase(DIM_W'(4),  DIM_W'(4),  DIM_W'(4),  100, 1'b0, 1'b1, 1'b0);
		run_phase(DIM_W'(0),  DIM_W'(0),  DIM_W'(0),  70,  1'b1, 1'b0, 1'b0);
		run_phase(DIM_W'(16), DIM_W'(16), DIM_W'(16), 50,  1'b1, 1'b1, 1'b0);
		run_phase(DIM_W'(31), DIM_W'(2),  DIM_W'(5),  80,  1'b1, 1'b0, 1'b0);
		run_phase(DIM_W'(5),  DIM_W'(3),  DIM_W'(7),  30,  1'b1, 1'b1, 1'b0);
		run_phase(DIM_W'(2),  DIM_W'(16), DIM_W'(1),  90,  1'b0, 1'b0, 1'b1);
		run_phase(DIM_W'(3),  DIM_W'(31), DIM_W'(3),  60,  1'b1, 1'b0, 1'b0);
		run_phase(DIM_W'(8),  DIM_W'(8),  DIM_W'(8),  75,  1'b1, 1'b1, 1'b0);

		idle_input(1);
		wait (pending_results.size() == 0);
		// any late extra result shows up as unexpected here
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
